// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions in the terminal writer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Types, codes and constants shared by the text cell terminal writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int ROWS_DEF = 32;
    localparam int COLS_DEF = 128;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] BLINK_RESET  = 8'd9;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [1:0] {
        K_PUT   = 2'd0,
        K_CLEAR = 2'd1,
        K_TICK  = 2'd2,
        K_READ  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        EV_CELL   = 2'd0,
        EV_REDRAW = 2'd1,
        EV_CURSOR = 2'd2,
        EV_READ   = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        OP_NEWLINE   = 3'd0,
        OP_BACKSPACE = 3'd1,
        OP_PUTC      = 3'd2,
        OP_CLEAR     = 3'd3,
        OP_TICK      = 3'd4,
        OP_READ      = 3'd5
    } t_op;

    typedef enum logic {
        CFG_FG_COLOR    = 1'b0,
        CFG_BLINK_LIMIT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_op         op;
        logic [7:0]  ch;
        logic [31:0] now;
        logic [4:0]  rrow;
        logic [6:0]  rcol;
        logic        rd_ok;
    } t_cmd;

    typedef struct packed {
        logic        last;
        logic        on;
        logic [31:0] color;
        logic [7:0]  ch;
        logic [7:0]  col;
        logic [4:0]  row;
        t_event      ev;
    } t_result;

    typedef struct packed {
        logic [31:0] fg;
        logic [7:0]  limit;
    } t_cfg;

    function automatic logic [7:0] shown_char(input logic [7:0] c);
        return (c == 8'd0) ? CH_SPACE : c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/text_cell_terminal_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_cell_terminal_writer_unit
// Character cell console with cursor, wrap, scroll, clear, blink and read.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser carries the kind (put, clear,
// blink tick, read) and tdata the character, tick time and read position.
// Results leave on m_axis, at most two per request, with tlast on the final
// one; requests that cause no result (plain newline, backspace at column 0,
// a tick before the blink limit) produce nothing.
// Colour and blink limit are written on the cfg port while the unit is idle;
// the user must keep to this, the unit does not enforce it. A two-entry
// queue separates decode from execution, so requests are taken while a
// result waits on m_axis. A character write or tick goes from the queue to
// the output state, a read or backspace through one store read first. A
// scroll clears one store row; a clear sweeps the whole store. After reset
// the same sweep blanks the store; no request is executed until it ends. A
// stalled m_axis holds the result and then backs up the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_cell_terminal_writer_unit #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // char_in[7:0], now_time[39:8], read_row[44:40], read_col[51:45], zero pad
    input  wire logic [tcw_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind[1:0]
    input  wire logic [1:0]                      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // event_res[1:0], row_out[6:2], col_out[14:7], char_out[22:15],
    // color_out[54:23], cursor_on[55]
    output logic [tcw_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                 m_axis_tlast,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_index,
    input  wire logic [31:0]                     i_cfg_data
);

    tcw_pkg::t_cfg    r_cfg;
    tcw_pkg::t_cmd    w_cmd;
    logic             w_cmd_valid;
    logic             w_pop;
    tcw_pkg::t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fg    <= '0;
            r_cfg.limit <= tcw_pkg::BLINK_RESET;
        end else if (i_cfg_we) begin
            unique case (tcw_pkg::t_cfg_idx'(i_cfg_index))
                tcw_pkg::CFG_FG_COLOR:    r_cfg.fg    <= i_cfg_data;
                tcw_pkg::CFG_BLINK_LIMIT: r_cfg.limit <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    tcw_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_pop       (w_pop),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd)
    );

    tcw_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_res       (w_res)
    );

    assign m_axis_tdata = {w_res.on, w_res.color, w_res.ch, w_res.col, w_res.row, w_res.ev};
    assign m_axis_tlast = w_res.last;

endmodule

`default_nettype wire

// ===== hdl/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front
// Accepts requests, decodes them into commands and queues them for the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_front #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [1:0]                     i_kind,
    input  wire logic [tcw_pkg::IN_DATA_W-1:0]  i_data,
    input  wire logic                           i_pop,
    output logic                                o_cmd_valid,
    output tcw_pkg::t_cmd                       o_cmd
);

    tcw_pkg::t_cmd w_cmd;
    tcw_pkg::t_cmd r_q [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_count;
    logic          w_push;

    always_comb begin
        w_cmd.ch    = i_data[7:0];
        w_cmd.now   = i_data[39:8];
        w_cmd.rrow  = i_data[44:40];
        w_cmd.rcol  = i_data[51:45];
        w_cmd.rd_ok = (32'(i_data[44:40]) < ROWS) && (32'(i_data[51:45]) < COLS);
        unique case (tcw_pkg::t_kind'(i_kind))
            tcw_pkg::K_PUT: begin
                if (i_data[7:0] == tcw_pkg::CH_NEWLINE) begin
                    w_cmd.op = tcw_pkg::OP_NEWLINE;
                end else if (i_data[7:0] == tcw_pkg::CH_BACKSPACE) begin
                    w_cmd.op = tcw_pkg::OP_BACKSPACE;
                end else begin
                    w_cmd.op = tcw_pkg::OP_PUTC;
                end
            end
            tcw_pkg::K_CLEAR: w_cmd.op = tcw_pkg::OP_CLEAR;
            tcw_pkg::K_TICK:  w_cmd.op = tcw_pkg::OP_TICK;
            default:          w_cmd.op = tcw_pkg::OP_READ;
        endcase
    end

    assign o_ready     = (r_count != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(w_push) - 2'(i_pop);
        end
    end

`include "assert_macros.svh"

    `TCW_ASSERT(a_no_pop_empty, i_clk, i_rst_n, i_pop |-> r_count != 2'd0, "pop from empty queue")
    `TCW_ASSERT(a_count_track, i_clk, i_rst_n, (w_push && !i_pop) |=> r_count == $past(r_count) + 2'd1, "queue count lost a push")
    `TCW_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> r_count == 2'd0, "queue not empty after reset")

endmodule

`default_nettype wire

// ===== hdl/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back
// Executes commands on the cell store and cursor, and drives the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_back #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tcw_pkg::t_cfg    i_cfg,
    input  wire logic             i_cmd_valid,
    input  wire tcw_pkg::t_cmd    i_cmd,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output tcw_pkg::t_result      o_res
);

    localparam int RW  = $clog2(ROWS);
    localparam int CW  = $clog2(COLS);
    localparam int CLW = $clog2(COLS + 1);
    localparam int AW  = RW + CW;

    typedef enum logic [4:0] {
        S_INIT  = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RD    = 5'b00100,
        S_SWEEP = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state           r_state;
    logic [RW-1:0]    r_row;
    logic [CLW-1:0]   r_col;
    logic [RW-1:0]    r_top;
    logic [31:0]      r_last_t;
    logic             r_shown;
    logic [AW-1:0]    r_sw_addr;
    logic             r_sw_all;
    logic [31:0]      r_sw_color;
    logic             r_after_put;
    logic [7:0]       r_put_ch;
    tcw_pkg::t_cmd    r_cmd;
    tcw_pkg::t_result r_res;
    logic             r_ovalid;
    tcw_pkg::t_result r_odata;
    logic [7:0]       r_rd_ch;
    logic [31:0]      r_rd_co;

    logic [7:0]       r_mem_ch [1 << AW];
    logic [31:0]      r_mem_co [1 << AW];

    logic             w_out_free;
    logic             w_bottom;
    logic             w_full;
    logic [RW-1:0]    w_top_inc;
    logic [RW-1:0]    w_eff_row;
    logic [CLW-1:0]   w_eff_col;
    logic [RW-1:0]    w_cur_phys;
    logic [RW-1:0]    w_eff_phys;
    logic [RW-1:0]    w_rd_phys;
    logic             w_sw_done;
    logic             w_we_ch;
    logic             w_we_co;
    logic [AW-1:0]    w_waddr;
    logic [7:0]       w_wch;
    logic [31:0]      w_wco;
    logic [AW-1:0]    w_raddr;

    function automatic logic [RW-1:0] f_phys(input logic [RW-1:0] top,
                                             input logic [RW-1:0] row);
        logic [RW:0] s;
        s = {1'b0, top} + {1'b0, row};
        if (s >= (RW + 1)'(ROWS)) begin
            s = s - (RW + 1)'(ROWS);
        end
        return s[RW-1:0];
    endfunction

    assign w_out_free = !r_ovalid || i_ready;
    assign w_bottom   = (r_row == RW'(ROWS - 1));
    assign w_full     = (r_col >= CLW'(COLS));
    assign w_top_inc  = (r_top == RW'(ROWS - 1)) ? '0 : r_top + RW'(1);
    assign w_eff_row  = w_full ? r_row + RW'(1) : r_row;
    assign w_eff_col  = w_full ? '0 : r_col;
    assign w_cur_phys = f_phys(r_top, r_row);
    assign w_eff_phys = f_phys(r_top, w_eff_row);
    assign w_rd_phys  = f_phys(r_top, RW'(i_cmd.rrow));
    assign w_sw_done  = r_sw_all ? (&r_sw_addr) : (&r_sw_addr[CW-1:0]);
    assign o_pop      = (r_state == S_IDLE) && i_cmd_valid;
    assign o_valid    = r_ovalid;
    assign o_res      = r_odata;

    // Store port control: sweeps, character writes and backspace blanking
    // share one write port; commands that need old cell data read here.
    always_comb begin
        w_we_ch = 1'b0;
        w_we_co = 1'b0;
        w_waddr = '0;
        w_wch   = tcw_pkg::CH_SPACE;
        w_wco   = i_cfg.fg;
        w_raddr = '0;
        unique case (r_state)
            S_INIT, S_SWEEP: begin
                w_we_ch = 1'b1;
                w_we_co = 1'b1;
                w_waddr = r_sw_addr;
                w_wco   = r_sw_color;
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        tcw_pkg::OP_BACKSPACE: begin
                            if (r_col != '0) begin
                                w_we_ch = 1'b1;
                                w_waddr = {w_cur_phys, CW'(r_col - CLW'(1))};
                                w_raddr = w_waddr;
                            end
                        end
                        tcw_pkg::OP_PUTC: begin
                            if (!(w_full && w_bottom)) begin
                                w_we_ch = 1'b1;
                                w_we_co = 1'b1;
                                w_waddr = {w_eff_phys, CW'(w_eff_col)};
                                w_wch   = i_cmd.ch;
                            end
                        end
                        tcw_pkg::OP_READ: begin
                            w_raddr = {w_rd_phys, CW'(i_cmd.rcol)};
                        end
                        default: ;
                    endcase
                end
            end
            S_OUT: begin
                if (w_out_free && r_after_put) begin
                    w_we_ch = 1'b1;
                    w_we_co = 1'b1;
                    w_waddr = {w_cur_phys, CW'(r_col)};
                    w_wch   = r_put_ch;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we_ch) begin
            r_mem_ch[w_waddr] <= w_wch;
        end
        if (w_we_co) begin
            r_mem_co[w_waddr] <= w_wco;
        end
        r_rd_ch <= r_mem_ch[w_raddr];
        r_rd_co <= r_mem_co[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_top       <= '0;
            r_last_t    <= '0;
            r_shown     <= 1'b1;
            r_sw_addr   <= '0;
            r_sw_all    <= 1'b1;
            r_sw_color  <= '0;
            r_after_put <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && w_out_free) begin
                r_ovalid <= 1'b1;
                r_odata  <= r_res;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_INIT: begin
                    r_sw_addr <= r_sw_addr + AW'(1);
                    if (&r_sw_addr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_SWEEP: begin
                    r_sw_addr <= r_sw_addr + AW'(1);
                    if (w_sw_done) begin
                        r_res.ev    <= tcw_pkg::EV_REDRAW;
                        r_res.row   <= '0;
                        r_res.col   <= '0;
                        r_res.ch    <= '0;
                        r_res.color <= '0;
                        r_res.on    <= 1'b0;
                        r_res.last  <= !r_after_put;
                        r_state     <= S_OUT;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        case (i_cmd.op)
                            tcw_pkg::OP_NEWLINE: begin
                                r_col <= '0;
                                if (w_bottom) begin
                                    r_top       <= w_top_inc;
                                    r_sw_addr   <= {r_top, CW'(0)};
                                    r_sw_all    <= 1'b0;
                                    r_sw_color  <= i_cfg.fg;
                                    r_after_put <= 1'b0;
                                    r_state     <= S_SWEEP;
                                end else begin
                                    r_row <= r_row + RW'(1);
                                end
                            end
                            tcw_pkg::OP_BACKSPACE: begin
                                if (r_col != '0) begin
                                    r_col   <= r_col - CLW'(1);
                                    r_state <= S_RD;
                                end
                            end
                            tcw_pkg::OP_PUTC: begin
                                if (w_full && w_bottom) begin
                                    r_col       <= '0;
                                    r_top       <= w_top_inc;
                                    r_sw_addr   <= {r_top, CW'(0)};
                                    r_sw_all    <= 1'b0;
                                    r_sw_color  <= i_cfg.fg;
                                    r_after_put <= 1'b1;
                                    r_put_ch    <= i_cmd.ch;
                                    r_state     <= S_SWEEP;
                                end else begin
                                    r_row       <= w_eff_row;
                                    r_col       <= w_eff_col + CLW'(1);
                                    r_res.ev    <= tcw_pkg::EV_CELL;
                                    r_res.row   <= 5'(w_eff_row);
                                    r_res.col   <= 8'(w_eff_col);
                                    r_res.ch    <= tcw_pkg::shown_char(i_cmd.ch);
                                    r_res.color <= i_cfg.fg;
                                    r_res.on    <= 1'b0;
                                    r_res.last  <= 1'b1;
                                    r_state     <= S_OUT;
                                end
                            end
                            tcw_pkg::OP_CLEAR: begin
                                r_row       <= '0;
                                r_col       <= '0;
                                r_top       <= '0;
                                r_sw_addr   <= '0;
                                r_sw_all    <= 1'b1;
                                r_sw_color  <= i_cfg.fg;
                                r_after_put <= 1'b0;
                                r_state     <= S_SWEEP;
                            end
                            tcw_pkg::OP_TICK: begin
                                if ((i_cmd.now - r_last_t) > 32'(i_cfg.limit)) begin
                                    r_last_t    <= i_cmd.now;
                                    r_shown     <= ~r_shown;
                                    r_res.ev    <= tcw_pkg::EV_CURSOR;
                                    r_res.row   <= 5'(r_row);
                                    r_res.col   <= 8'(r_col);
                                    r_res.ch    <= '0;
                                    r_res.color <= '0;
                                    r_res.on    <= ~r_shown;
                                    r_res.last  <= 1'b1;
                                    r_state     <= S_OUT;
                                end
                            end
                            tcw_pkg::OP_READ: begin
                                if (i_cmd.rd_ok) begin
                                    r_state <= S_RD;
                                end else begin
                                    r_res.ev    <= tcw_pkg::EV_READ;
                                    r_res.row   <= i_cmd.rrow;
                                    r_res.col   <= {1'b0, i_cmd.rcol};
                                    r_res.ch    <= tcw_pkg::CH_SPACE;
                                    r_res.color <= '0;
                                    r_res.on    <= 1'b0;
                                    r_res.last  <= 1'b1;
                                    r_state     <= S_OUT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: begin
                    r_res.on    <= 1'b0;
                    r_res.last  <= 1'b1;
                    r_res.color <= r_rd_co;
                    if (r_cmd.op == tcw_pkg::OP_READ) begin
                        r_res.ev  <= tcw_pkg::EV_READ;
                        r_res.row <= r_cmd.rrow;
                        r_res.col <= {1'b0, r_cmd.rcol};
                        r_res.ch  <= tcw_pkg::shown_char(r_rd_ch);
                    end else begin
                        r_res.ev  <= tcw_pkg::EV_CELL;
                        r_res.row <= 5'(r_row);
                        r_res.col <= 8'(r_col);
                        r_res.ch  <= tcw_pkg::CH_SPACE;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        if (r_after_put) begin
                            // The wrapped character lands at column 0 of the new bottom row.
                            r_after_put <= 1'b0;
                            r_col       <= r_col + CLW'(1);
                            r_res.ev    <= tcw_pkg::EV_CELL;
                            r_res.row   <= 5'(r_row);
                            r_res.col   <= 8'(r_col);
                            r_res.ch    <= tcw_pkg::shown_char(r_put_ch);
                            r_res.color <= i_cfg.fg;
                            r_res.on    <= 1'b0;
                            r_res.last  <= 1'b1;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "assert_macros.svh"

    `TCW_ASSERT(a_row_range, i_clk, i_rst_n, 32'(r_row) < ROWS, "cursor row out of range")
    `TCW_ASSERT(a_col_range, i_clk, i_rst_n, 32'(r_col) <= COLS, "cursor column beyond last cell")
    `TCW_ASSERT(a_clear_home, i_clk, i_rst_n, (r_state == S_SWEEP && r_sw_all) |-> (r_top == '0 && r_row == '0 && r_col == '0), "clear sweep without homed cursor")
    `TCW_ASSERT(a_wrap_col0, i_clk, i_rst_n, (r_state == S_SWEEP && r_after_put) |-> (r_col == '0 && w_bottom), "wrapped write not at bottom row start")

endmodule

`default_nettype wire

// ===== verif/text_cell_terminal_writer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// text_cell_terminal_writer_unit_tb
// Self-checking bench for the terminal writer: a clocked driver feeds queued
// requests with random gaps, a clocked monitor takes results with random
// stalls and compares each with a behavioral model of the console screen.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_cell_terminal_writer_unit_tb;
    import tcw_pkg::*;

    localparam int NR = ROWS_DEF;
    localparam int NC = COLS_DEF;
    localparam int SWEEP = NR * NC;

    typedef struct {
        t_kind       kind;
        logic [7:0]  ch;
        logic [31:0] now;
        logic [4:0]  rrow;
        logic [6:0]  rcol;
    } req_t;

    typedef struct {
        t_event      ev;
        logic [4:0]  row;
        logic [7:0]  col;
        logic [7:0]  ch;
        logic [31:0] color;
        logic        on;
        logic        last;
    } res_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic i_cfg_we = 1'b0;
    logic i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = '0;

    always #5 i_clk = ~i_clk;

    text_cell_terminal_writer_unit DUT (.*);

    // Screen model.
    logic [7:0]  scr_char [SWEEP];
    logic [31:0] scr_color [SWEEP];
    int unsigned cur_row, cur_col, top;
    logic [31:0] last_toggle, fg;
    logic [7:0]  blink_lim;
    logic        shown;

    req_t pending_reqs[$];
    res_t expected_results[$];
    int   fail_count = 0;
    bit   hold_sink = 0;
    int   hold_cycles = 0;

    function automatic int cell_at(int unsigned r, int unsigned c);
        return ((top + r) % NR) * NC + (c % NC);
    endfunction

    function automatic void push_res(t_event ev, logic [4:0] r, logic [7:0] c,
                                     logic [7:0] ch, logic [31:0] col, logic on);
        res_t x;
        x.ev = ev; x.row = r; x.col = c; x.ch = ch; x.color = col; x.on = on;
        x.last = 1'b0;
        expected_results.push_back(x);
    endfunction

    function automatic bit advance_row();
        int b;
        cur_col = 0;
        cur_row++;
        if (cur_row >= NR) begin
            top = (top + 1) % NR;
            cur_row = NR - 1;
            b = cell_at(NR - 1, 0);
            for (int c = 0; c < NC; c++) begin
                scr_char[b + c] = CH_SPACE;
                scr_color[b + c] = fg;
            end
            return 1;
        end
        return 0;
    endfunction

    function automatic void predict_console(req_t q);
        int n0, i;
        n0 = expected_results.size();
        case (q.kind)
            K_PUT: begin
                if (q.ch == CH_NEWLINE) begin
                    if (advance_row()) push_res(EV_REDRAW, 0, 0, 0, 0, 0);
                end else if (q.ch == CH_BACKSPACE) begin
                    if (cur_col > 0) begin
                        cur_col--;
                        i = cell_at(cur_row, cur_col);
                        scr_char[i] = CH_SPACE;
                        push_res(EV_CELL, cur_row, cur_col, CH_SPACE, scr_color[i], 0);
                    end
                end else begin
                    if (cur_col >= NC)
                        if (advance_row()) push_res(EV_REDRAW, 0, 0, 0, 0, 0);
                    i = cell_at(cur_row, cur_col);
                    scr_char[i] = q.ch;
                    scr_color[i] = fg;
                    push_res(EV_CELL, cur_row, cur_col,
                             (q.ch == 0) ? CH_SPACE : q.ch, fg, 0);
                    cur_col++;
                end
            end
            K_CLEAR: begin
                for (int k = 0; k < SWEEP; k++) begin
                    scr_char[k] = CH_SPACE;
                    scr_color[k] = fg;
                end
                cur_row = 0; cur_col = 0; top = 0;
                push_res(EV_REDRAW, 0, 0, 0, 0, 0);
            end
            K_TICK: begin
                if (32'(q.now - last_toggle) > {24'd0, blink_lim}) begin
                    last_toggle = q.now;
                    shown = ~shown;
                    push_res(EV_CURSOR, cur_row, cur_col, 0, 0, shown);
                end
            end
            default: begin
                if (q.rrow < NR && q.rcol < NC) begin
                    i = cell_at(q.rrow, q.rcol);
                    push_res(EV_READ, q.rrow, q.rcol,
                             (scr_char[i] == 0) ? CH_SPACE : scr_char[i], scr_color[i], 0);
                end else begin
                    push_res(EV_READ, q.rrow, q.rcol, CH_SPACE, 0, 0);
                end
            end
        endcase
        if (expected_results.size() > n0)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    // Driver.
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_console(pending_reqs.pop_front());
                src_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            end
            if (src_gap > 0 && !(s_axis_tvalid && !s_axis_tready)) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_reqs[0].kind;
                s_axis_tdata  <= {4'd0, pending_reqs[0].rcol, pending_reqs[0].rrow,
                                  pending_reqs[0].now, pending_reqs[0].ch};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor.
    int sink_gap = 0;
    always @(posedge i_clk) begin
        res_t e;
        t_event got_ev;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_ev = t_event'(m_axis_tdata[1:0]);
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (got_ev !== e.ev) begin
                        $error("event_res exp %0d got %0d", e.ev, got_ev); fail_count++;
                    end
                    if (m_axis_tdata[6:2] !== e.row) begin
                        $error("row_out exp %0d got %0d", e.row, m_axis_tdata[6:2]);
                        fail_count++;
                    end
                    if (m_axis_tdata[14:7] !== e.col) begin
                        $error("col_out exp %0d got %0d", e.col, m_axis_tdata[14:7]);
                        fail_count++;
                    end
                    if (m_axis_tdata[22:15] !== e.ch) begin
                        $error("char_out exp %0d got %0d", e.ch, m_axis_tdata[22:15]);
                        fail_count++;
                    end
                    if (m_axis_tdata[54:23] !== e.color) begin
                        $error("color_out exp %h got %h", e.color, m_axis_tdata[54:23]);
                        fail_count++;
                    end
                    if (m_axis_tdata[55] !== e.on) begin
                        $error("cursor_on exp %0d got %0d", e.on, m_axis_tdata[55]);
                        fail_count++;
                    end
                    if (m_axis_tlast !== e.last) begin
                        $error("last exp %0d got %0d", e.last, m_axis_tlast); fail_count++;
                    end
                end
                sink_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end else if (hold_sink) begin
                hold_sink = 0;
                hold_cycles = 400;
                m_axis_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic add_req(t_kind k, logic [7:0] c, logic [31:0] t,
                           logic [4:0] r, logic [6:0] col);
        req_t q;
        q.kind = k; q.ch = c; q.now = t; q.rrow = r; q.rcol = col;
        pending_reqs.push_back(q);
    endtask

    // Waits until every request has gone in and every result has come out,
    // then idles so that any clear sweep can finish.
    task automatic drain();
        while (pending_reqs.size() > 0 || expected_results.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (SWEEP + 200) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FG_COLOR) fg = v; else blink_lim = v[7:0];
    endtask

    // Mostly printable text and newlines, with some noise and other kinds.
    task automatic random_batch(int n, logic [31:0] tbase);
        int sel;
        logic [31:0] t;
        t = tbase;
        repeat (n) begin
            sel = $urandom_range(0, 99);
            t += $urandom_range(0, 40);
            if (sel < 55)      add_req(K_PUT, $urandom_range(33, 126), 0, 0, 0);
            else if (sel < 63) add_req(K_PUT, CH_NEWLINE, $urandom, 0, 0);
            else if (sel < 68) add_req(K_PUT, CH_BACKSPACE, 0, 0, 0);
            else if (sel < 73) add_req(K_PUT, $urandom_range(0, 255), $urandom, 0, 0);
            else if (sel < 83) add_req(K_TICK, $urandom, t, 0, 0);
            else if (sel < 85) add_req(K_TICK, $urandom, $urandom, 0, 0);
            else if (sel < 99) add_req(K_READ, $urandom,
                                       $urandom, $urandom_range(0, 31),
                                       ($urandom_range(0, 9) == 0) ? 7'd127 :
                                       $urandom_range(0, NC - 2));
            else               add_req(K_CLEAR, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        for (int k = 0; k < SWEEP; k++) begin
            scr_char[k] = CH_SPACE;
            scr_color[k] = '0;
        end
        cur_row = 0; cur_col = 0; top = 0;
        last_toggle = 0; shown = 1; fg = 0; blink_lim = BLINK_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SWEEP + 200) @(posedge i_clk);

        // Directed: reads of reset store, backspace at home, edges.
        add_req(K_READ, 0, 0, 0, 0);
        add_req(K_READ, 8'hFF, 32'hFFFF_FFFF, 5'd31, 7'd127);
        add_req(K_PUT, CH_BACKSPACE, 0, 0, 0);
        add_req(K_PUT, 8'd0, 0, 0, 0);
        add_req(K_PUT, 8'hFF, 0, 0, 0);
        add_req(K_PUT, CH_BACKSPACE, 0, 0, 0);
        add_req(K_READ, 0, 0, 0, 0);
        add_req(K_READ, 0, 0, 0, 1);
        add_req(K_TICK, 0, 32'd9, 0, 0);
        add_req(K_TICK, 0, 32'd10, 0, 0);
        add_req(K_TICK, 0, 32'd5, 0, 0);
        add_req(K_PUT, CH_NEWLINE, 0, 0, 0);
        drain();
        write_cfg(CFG_FG_COLOR, 32'hFFFF_FFFF);
        write_cfg(CFG_BLINK_LIMIT, 32'd0);
        // Fill a whole row to reach column COLS, then wrap.
        repeat (NC) add_req(K_PUT, 8'h41, 0, 0, 0);
        add_req(K_TICK, 0, 32'd100, 0, 0);
        add_req(K_PUT, 8'h42, 0, 0, 0);
        // Newlines to the bottom and past it to scroll.
        repeat (NR + 1) add_req(K_PUT, CH_NEWLINE, 0, 0, 0);
        repeat (NC) add_req(K_PUT, 8'h43, 0, 0, 0);
        add_req(K_PUT, 8'h44, 0, 0, 0);
        add_req(K_READ, 0, 0, 5'd31, 7'd0);
        add_req(K_READ, 0, 0, 5'd0, 7'd5);
        add_req(K_CLEAR, 0, 0, 0, 0);
        add_req(K_READ, 0, 0, 5'd3, 7'd3);
        drain();

        write_cfg(CFG_FG_COLOR, 32'h0000_0000);
        write_cfg(CFG_BLINK_LIMIT, 32'd255);
        random_batch(335, 32'd0);
        hold_sink = 1;
        drain();
        write_cfg(CFG_FG_COLOR, $urandom);
        write_cfg(CFG_BLINK_LIMIT, $urandom_range(0, 30));
        random_batch(335, 32'hFFFF_FF00);
        drain();
        write_cfg(CFG_FG_COLOR, $urandom);
        write_cfg(CFG_BLINK_LIMIT, 32'd0);
        random_batch(335, $urandom);
        hold_sink = 1;
        drain();
        write_cfg(CFG_FG_COLOR, $urandom);
        write_cfg(CFG_BLINK_LIMIT, $urandom_range(5, 60));
        random_batch(335, $urandom);
        drain();

        if (fail_count == 0 && expected_results.size() == 0)
            $display("[text_cell_terminal_writer_unit] OK");
        else
            $display("[text_cell_terminal_writer_unit] ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("[text_cell_terminal_writer_unit] ERROR");
        $finish;
    end

endmodule
